// ===== hdl/cpoc_pkg.sv =====
// Shared types and constants for the contig pair orientation checker.
// Holds the transfer payload structs, code enums and the score argmax helper.
// No dependencies.
package cpoc_pkg;

  localparam int unsigned IdW    = 12;
  localparam int unsigned OrientW = 2;
  localparam int unsigned ChromW = 8;
  localparam int unsigned PosW   = 24;
  localparam int unsigned ScoreW = 16;

  typedef logic [IdW-1:0]    id_t;
  typedef logic [OrientW-1:0] orient_t;
  typedef logic [ChromW-1:0] chrom_t;
  typedef logic [PosW-1:0]   pos_t;
  typedef logic [ScoreW-1:0] score_t;

  localparam orient_t ORIENT_PLUS  = 2'd0;
  localparam orient_t ORIENT_MINUS = 2'd1;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_CHECK = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STATUS_CORRECT      = 2'd0,
    STATUS_UNMATCHED    = 2'd1,
    STATUS_DIFF_CHROM   = 2'd2,
    STATUS_WRONG_ORIENT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    JOIN_FF = 2'd0,
    JOIN_FR = 2'd1,
    JOIN_RF = 2'd2,
    JOIN_RR = 2'd3
  } jtype_e;

  typedef struct packed {
    func_e   func;
    id_t     first_contig;
    id_t     second_contig;
    orient_t orientation;
    chrom_t  chromosome;
    pos_t    order_position;
    score_t  score_fwd_fwd;
    score_t  score_fwd_rev;
    score_t  score_rev_fwd;
    score_t  score_rev_rev;
  } in_t;

  typedef struct packed {
    status_e status;
    jtype_e  claimed_type;
    pos_t    step_distance;
  } out_t;

  // argmax, ties keep the earlier type
  function automatic jtype_e pick_claimed(score_t s0, score_t s1, score_t s2, score_t s3);
    jtype_e best;
    score_t top;
    best = JOIN_FF;
    top  = s0;
    if (s1 > top) begin
      best = JOIN_FR;
      top  = s1;
    end
    if (s2 > top) begin
      best = JOIN_RF;
      top  = s2;
    end
    if (s3 > top) begin
      best = JOIN_RR;
    end
    return best;
  endfunction

endpackage

// ===== hdl/cpoc_table.sv =====
// Contig mapping table: one synchronous memory, one write and one read port.
// Runs a clearing sweep over every entry after reset. Uses cpoc_pkg.
module cpoc_table
  import cpoc_pkg::*;
#(
  parameter int unsigned SLOTS = 4096,
  parameter int unsigned WIDTH = 35
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  logic [$clog2(SLOTS)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(SLOTS)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  output logic                     clearing_o
);

  localparam int unsigned AddrW = $clog2(SLOTS);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(SLOTS - 1);

  logic [WIDTH-1:0] mem [SLOTS];
  logic [WIDTH-1:0] rd_data_q;
  logic [AddrW-1:0] clr_q, clr_d;
  logic             clearing_q, clearing_d;

  always_comb begin
    clr_d      = clr_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      clr_d = clr_q + AddrW'(1);
      if (clr_q == LastAddr) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clearing_q <= 1'b1;
    end else begin
      clr_q      <= clr_d;
      clearing_q <= clearing_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem[clr_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clearing_o = clearing_q;

endmodule

// ===== hdl/contig_pair_orientation_checker_unit.sv =====
// Contig pair orientation checker, top level.
// Uses cpoc_pkg and cpoc_table.
//
// Usage:
// - Input channel in_valid_i / in_stall_o / in_data_i carries load and check
//   items. A transfer happens on a rising edge with valid high, stall low.
// - A load writes one table entry at its transfer edge and gives no result;
//   an id at or beyond CONTIG_SLOTS is dropped. The block takes a new item in
//   the next cycle.
// - A check reads both entries through the table's single read port, one per
//   cycle, so in_stall_o is high while the second entry is read. The result
//   is registered into the output register in ST_FINISH once that register frees.
// - Output channel out_valid_o / out_stall_i / out_data_o: one result per
//   check. While the receiver stalls, the result holds; the next check can be
//   taken and finish its reads, then waits until the output register frees.
// - Reset: after rst_ni releases, a sweep clears the table, one entry per
//   cycle, CONTIG_SLOTS cycles in all, with in_stall_o high.
module contig_pair_orientation_checker_unit
  import cpoc_pkg::*;
#(
  parameter int unsigned CONTIG_SLOTS    = 4096,
  parameter int unsigned POSITION_BITS   = 24,
  parameter int unsigned CHROMOSOME_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned IdxW = $clog2(CONTIG_SLOTS);
  localparam int unsigned CmpW = ((IdxW > IdW) ? IdxW : IdW) + 1;

  typedef struct packed {
    logic                       vld;
    orient_t                    orient;
    logic [CHROMOSOME_BITS-1:0] chrom;
    logic [POSITION_BITS-1:0]   pos;
  } ent_t;

  localparam int unsigned EntW = $bits(ent_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SECOND,
    ST_FINISH
  } state_e;

  state_e            state_q, state_d;
  logic [IdxW-1:0]   id2_q, id2_d;
  logic              ok1_q, ok1_d, ok2_q, ok2_d;
  jtype_e            claimed_q, claimed_d;
  ent_t              ent1_q, ent1_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  logic              clearing;
  logic              in_xfer, is_check, out_free, finish;
  logic              ok1_in, ok2_in;
  logic              wr_en, rd_en;
  logic [IdxW-1:0]   rd_addr;
  ent_t              wr_ent, rd_ent;
  logic [EntW-1:0]   rd_raw;

  logic                     later, unknown;
  logic [1:0]               code;
  logic [POSITION_BITS-1:0] span;
  out_t                     res;

  assign ok1_in = CmpW'(in_data_i.first_contig) < CmpW'(CONTIG_SLOTS);
  assign ok2_in = CmpW'(in_data_i.second_contig) < CmpW'(CONTIG_SLOTS);

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = clearing || (state_q == ST_SECOND) ||
                      ((state_q == ST_FINISH) && !out_free);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign is_check   = (in_data_i.func == FUNC_CHECK);
  assign finish     = (state_q == ST_FINISH) && out_free;

  assign wr_en          = in_xfer && !is_check && ok1_in;
  assign wr_ent.vld     = 1'b1;
  assign wr_ent.orient  = in_data_i.orientation;
  assign wr_ent.chrom   = CHROMOSOME_BITS'(in_data_i.chromosome);
  assign wr_ent.pos     = POSITION_BITS'(in_data_i.order_position);

  assign rd_en   = (in_xfer && is_check) || (state_q == ST_SECOND);
  assign rd_addr = (state_q == ST_SECOND) ? id2_q
                                          : IdxW'(in_data_i.first_contig);

  cpoc_table #(
    .SLOTS(CONTIG_SLOTS),
    .WIDTH(EntW)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (IdxW'(in_data_i.first_contig)),
    .wr_data_i (wr_ent),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_raw),
    .clearing_o(clearing)
  );

  assign rd_ent = rd_raw;

  // judge: first entry registered, second entry straight from the memory
  assign later   = ent1_q.pos > rd_ent.pos;
  assign unknown = ((ent1_q.orient != ORIENT_PLUS) && (ent1_q.orient != ORIENT_MINUS)) ||
                   ((rd_ent.orient != ORIENT_PLUS) && (rd_ent.orient != ORIENT_MINUS));
  assign code    = later ? ~{ent1_q.orient == ORIENT_MINUS, rd_ent.orient == ORIENT_MINUS}
                         :  {ent1_q.orient == ORIENT_MINUS, rd_ent.orient == ORIENT_MINUS};
  assign span    = later ? (ent1_q.pos - rd_ent.pos) : (rd_ent.pos - ent1_q.pos);

  always_comb begin
    res.claimed_type  = claimed_q;
    res.step_distance = '0;
    priority if (!(ok1_q && ok2_q && ent1_q.vld && rd_ent.vld)) begin
      res.status = STATUS_UNMATCHED;
    end else if (ent1_q.chrom != rd_ent.chrom) begin
      res.status = STATUS_DIFF_CHROM;
    end else if (unknown || (jtype_e'(code) != claimed_q)) begin
      res.status = STATUS_WRONG_ORIENT;
    end else begin
      res.status        = STATUS_CORRECT;
      res.step_distance = pos_t'(span);
    end
  end

  always_comb begin
    state_d     = state_q;
    id2_d       = id2_q;
    ok1_d       = ok1_q;
    ok2_d       = ok2_q;
    claimed_d   = claimed_q;
    ent1_d      = ent1_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (in_xfer && is_check) begin
      id2_d     = IdxW'(in_data_i.second_contig);
      ok1_d     = ok1_in;
      ok2_d     = ok2_in;
      claimed_d = pick_claimed(in_data_i.score_fwd_fwd, in_data_i.score_fwd_rev,
                               in_data_i.score_rev_fwd, in_data_i.score_rev_rev);
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && is_check) begin
          state_d = ST_SECOND;
        end
      end
      ST_SECOND: begin
        ent1_d  = rd_ent;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (finish) begin
          out_valid_d = 1'b1;
          out_d       = res;
          state_d     = (in_xfer && is_check) ? ST_SECOND : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id2_q     <= id2_d;
    ok1_q     <= ok1_d;
    ok2_q     <= ok2_d;
    claimed_q <= claimed_d;
    ent1_q    <= ent1_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/cpoc_checker.sv =====
// Port-level checks for the contig pair orientation checker.
// Uses cpoc_pkg; bound to contig_pair_orientation_checker_unit below.
module cpoc_checker
  import cpoc_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  logic in_xfer;
  logic chk_xfer;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign chk_xfer = in_xfer && (in_data_i.func == FUNC_CHECK);

  // check needs two table reads
  a_check_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_xfer |=> in_stall_o)
    else $error("check transfer followed by another transfer in the next cycle");

  // a fresh result always traces back to an earlier check transfer
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(chk_xfer, 3))
    else $error("result appeared without a matching check transfer");

  a_dist_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != STATUS_CORRECT)) |->
      (out_data_o.step_distance == '0))
    else $error("nonzero distance on a failed check");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

bind contig_pair_orientation_checker_unit cpoc_checker u_cpoc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

// ===== sim/tb_contig_pair_orientation_checker_unit.sv =====
// Testbench for contig_pair_orientation_checker_unit: directed and random load/check
// traffic with random idling, scored against a local contig map predictor.
// Depends on cpoc_pkg and the unit RTL.
`timescale 1ns / 1ps

module tb_contig_pair_orientation_checker_unit;
  import cpoc_pkg::*;

  localparam int unsigned SLOTS          = 1 << IdW;
  localparam int          JOIN_UNKNOWN   = 4;
  localparam int          WATCHDOG_LIMIT = 20000;
  localparam int          POOL_SIZE      = 32;

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_stall_o;
  in_t  in_data;
  logic out_valid_o;
  logic out_stall;
  out_t out_data_o;

  contig_pair_orientation_checker_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o)
  );

  // contig map mirror
  bit      map_valid  [SLOTS];
  orient_t map_orient [SLOTS];
  chrom_t  map_chrom  [SLOTS];
  pos_t    map_pos    [SLOTS];

  out_t        verdict_q[$];
  int          mismatch_count;
  int          quiet_cycles;
  bit          src_gaps_on;
  bit          sink_gaps_on;
  int unsigned sink_hold_len;
  int unsigned hold_reqs;
  id_t         pool[POOL_SIZE];
  chrom_t      chrom_set[2];

  initial begin
    clk_i = 1'b0;
  end

  always #4 clk_i = ~clk_i;

  // join type implied by two loaded entries, or JOIN_UNKNOWN if either strand is unknown
  function automatic int join_of(id_t a, id_t b);
    int code;
    if (map_orient[a] > ORIENT_MINUS || map_orient[b] > ORIENT_MINUS) begin
      return JOIN_UNKNOWN;
    end
    code = {map_orient[a][0], map_orient[b][0]};
    return (map_pos[a] > map_pos[b]) ? 3 - code : code;
  endfunction

  function automatic void predict_transfer(in_t it);
    out_t   v;
    score_t sc[4];
    int     best;
    id_t    a;
    id_t    b;
    a = it.first_contig;
    b = it.second_contig;
    if (it.func == FUNC_LOAD) begin
      map_valid[a]  = 1'b1;
      map_orient[a] = it.orientation;
      map_chrom[a]  = it.chromosome;
      map_pos[a]    = it.order_position;
      return;
    end
    sc[0] = it.score_fwd_fwd;
    sc[1] = it.score_fwd_rev;
    sc[2] = it.score_rev_fwd;
    sc[3] = it.score_rev_rev;
    best = 0;
    for (int k = 1; k < 4; k++) begin
      if (sc[k] > sc[best]) best = k;
    end
    v.claimed_type  = jtype_e'(best);
    v.step_distance = '0;
    if (!map_valid[a] || !map_valid[b]) begin
      v.status = STATUS_UNMATCHED;
    end else if (map_chrom[a] != map_chrom[b]) begin
      v.status = STATUS_DIFF_CHROM;
    end else if (join_of(a, b) != best) begin
      v.status = STATUS_WRONG_ORIENT;
    end else begin
      v.status        = STATUS_CORRECT;
      v.step_distance = (map_pos[a] > map_pos[b]) ? map_pos[a] - map_pos[b]
                                                  : map_pos[b] - map_pos[a];
    end
    verdict_q.push_back(v);
  endfunction

  function automatic in_t load_item(id_t id, orient_t o, chrom_t c, pos_t p);
    in_t          it;
    logic [127:0] fill;
    fill = {$urandom, $urandom, $urandom, $urandom};
    it   = fill[$bits(in_t)-1:0];
    it.func           = FUNC_LOAD;
    it.first_contig   = id;
    it.orientation    = o;
    it.chromosome     = c;
    it.order_position = p;
    return it;
  endfunction

  function automatic in_t check_item(id_t a, id_t b, score_t s0, score_t s1,
                                     score_t s2, score_t s3);
    in_t          it;
    logic [127:0] fill;
    fill = {$urandom, $urandom, $urandom, $urandom};
    it   = fill[$bits(in_t)-1:0];
    it.func          = FUNC_CHECK;
    it.first_contig  = a;
    it.second_contig = b;
    it.score_fwd_fwd = s0;
    it.score_fwd_rev = s1;
    it.score_rev_fwd = s2;
    it.score_rev_rev = s3;
    return it;
  endfunction

  function automatic in_t random_load(id_t id);
    orient_t o;
    chrom_t  c;
    pos_t    p;
    case ($urandom_range(0, 7))
      0, 1, 2: o = ORIENT_PLUS;
      3, 4, 5: o = ORIENT_MINUS;
      6:       o = 2'd2;
      default: o = 2'd3;
    endcase
    c = ($urandom_range(0, 3) == 0) ? chrom_t'($urandom) : chrom_set[$urandom_range(0, 1)];
    case ($urandom_range(0, 15))
      0:       p = '0;
      1:       p = '1;
      default: p = pos_t'($urandom);
    endcase
    return load_item(id, o, c, p);
  endfunction

  // scores mostly favor the join the map implies, so correct joins show up often
  function automatic in_t random_check(id_t a, id_t b);
    score_t sc[4];
    score_t top;
    int     target;
    int     mode;
    target = $urandom_range(0, 3);
    if (map_valid[a] && map_valid[b] && join_of(a, b) != JOIN_UNKNOWN) begin
      target = join_of(a, b);
    end
    for (int k = 0; k < 4; k++) sc[k] = score_t'($urandom);
    mode = $urandom_range(0, 7);
    if (mode == 6) begin
      top = score_t'($urandom);
      for (int k = 0; k < 4; k++) begin
        sc[k] = ($urandom_range(0, 1) == 1) ? top : score_t'($urandom_range(0, top));
      end
    end else if (mode < 6) begin
      if (mode == 5) target = $urandom_range(0, 3);
      top = ($urandom_range(0, 7) == 0) ? score_t'('1) : score_t'($urandom_range(1, 65535));
      for (int k = 0; k < 4; k++) sc[k] = score_t'($urandom_range(0, top - 1));
      sc[target] = top;
    end
    return check_item(a, b, sc[0], sc[1], sc[2], sc[3]);
  endfunction

  task automatic send_item(input in_t it);
    if (src_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_transfer(it);
  endtask

  task automatic wait_all_results();
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_mixed(int unsigned count);
    id_t a;
    id_t b;
    chrom_set[0] = chrom_t'($urandom);
    chrom_set[1] = chrom_t'($urandom);
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool[i] = id_t'($urandom);
      send_item(random_load(pool[i]));
    end
    for (int unsigned n = 0; n < count; n++) begin
      a = ($urandom_range(0, 9) == 0) ? id_t'($urandom) : pool[$urandom_range(0, POOL_SIZE - 1)];
      b = ($urandom_range(0, 9) == 0) ? id_t'($urandom) : pool[$urandom_range(0, POOL_SIZE - 1)];
      if ($urandom_range(0, 3) == 0) begin
        send_item(random_load(a));
      end else begin
        if ($urandom_range(0, 15) == 0) b = a;
        send_item(random_check(a, b));
      end
    end
  endtask

  task automatic test_directed();
    send_item(check_item(12'd0, 12'hFFF, 16'd0, 16'd0, 16'd0, 16'd0));
    send_item(load_item(12'd0, ORIENT_PLUS, 8'd0, 24'd0));
    send_item(load_item(12'hFFF, ORIENT_PLUS, 8'd0, 24'hFFFFFF));
    send_item(check_item(12'd0, 12'hFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0));
    send_item(check_item(12'hFFF, 12'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF));
    send_item(load_item(12'd1, ORIENT_MINUS, 8'd0, 24'd100));
    send_item(check_item(12'd0, 12'd1, 16'd0, 16'hFFFF, 16'd0, 16'd0));
    send_item(check_item(12'd1, 12'd0, 16'd0, 16'd10, 16'd0, 16'd9));
    send_item(check_item(12'd1, 12'd1, 16'd0, 16'd0, 16'd0, 16'd1));
    send_item(check_item(12'd1, 12'hFFF, 16'd0, 16'd0, 16'd5, 16'd0));
    send_item(check_item(12'hFFF, 12'd1, 16'd0, 16'd0, 16'd5, 16'd0));
    // unknown strand never matches
    send_item(load_item(12'd2, 2'd2, 8'd0, 24'd50));
    send_item(check_item(12'd0, 12'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(load_item(12'd3, 2'd3, 8'hFF, 24'd7));
    send_item(load_item(12'd4, ORIENT_PLUS, 8'hFF, 24'd5));
    send_item(check_item(12'd4, 12'd3, 16'd1, 16'd2, 16'd3, 16'd4));
    send_item(check_item(12'd4, 12'd0, 16'd5, 16'd5, 16'd5, 16'd5));
    // overwrite of a loaded entry
    send_item(load_item(12'd4, ORIENT_MINUS, 8'd0, 24'd200));
    send_item(check_item(12'd0, 12'd4, 16'd3, 16'd7, 16'd2, 16'd7));
    send_item(check_item(12'd4, 12'd1, 16'd9, 16'd1, 16'd1, 16'd1));
    send_item(check_item(12'd1, 12'd4, 16'd0, 16'd0, 16'd8, 16'd0));
    send_item(check_item(12'd0, 12'hFFE, 16'd1, 16'd0, 16'd0, 16'd0));
    send_item(load_item(12'hFFE, ORIENT_MINUS, 8'hFF, 24'hFFFFFF));
    send_item(check_item(12'hFFF, 12'hFFE, 16'd0, 16'd1, 16'd0, 16'd0));
  endtask

  task automatic test_random_traffic();
    run_mixed(500);
  endtask

  task automatic test_output_backpressure();
    in_valid      <= 1'b0;
    src_gaps_on   = 1'b0;
    sink_hold_len = 400;
    hold_reqs++;
    @(posedge clk_i);
    run_mixed(80);
    in_valid <= 1'b0;
    wait_all_results();
    src_gaps_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    run_mixed(60);
    in_valid <= 1'b0;
    wait_all_results();
    repeat (4) @(posedge clk_i);
    run_mixed(60);
  endtask

  task automatic test_no_idle();
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    run_mixed(250);
  endtask

  // sink stall: random short bursts, or one long hold on request
  initial begin
    int unsigned holds_done;
    holds_done = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_reqs != holds_done) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (sink_hold_len) @(posedge clk_i);
        out_stall <= 1'b0;
      end else if (sink_gaps_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_result
    out_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $error("result transfer with no check pending");
        mismatch_count++;
      end else begin
        want = verdict_q.pop_front();
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data_o.status);
          mismatch_count++;
        end
        if (out_data_o.claimed_type !== want.claimed_type) begin
          $error("claimed_type: expected %0d, actual %0d", want.claimed_type,
                 out_data_o.claimed_type);
          mismatch_count++;
        end
        if (out_data_o.step_distance !== want.step_distance) begin
          $error("step_distance: expected %0d, actual %0d", want.step_distance,
                 out_data_o.step_distance);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    src_gaps_on    = 1'b1;
    sink_gaps_on   = 1'b1;
    sink_hold_len  = 0;
    rst_ni   <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_traffic();
    test_output_backpressure();
    test_sender_pause();
    test_no_idle();
    in_valid <= 1'b0;
    wait_all_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/cpoc_pkg.sv
hdl/cpoc_table.sv
hdl/contig_pair_orientation_checker_unit.sv
hdl/cpoc_checker.sv
sim/tb_contig_pair_orientation_checker_unit.sv
